FILE: rtl/kde_pkg.sv
// Shared types and constants of the key debounce event table.
// Used by the front, queue, back and top level; depends on nothing else.
package kde_pkg;

    // Field widths fixed by the item format
    localparam int KEY_W      = 7;
    localparam int SLOT_W     = 4;
    localparam int HOLD_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Default sizes of the per-key state and the slot table
    localparam int NUM_KEYS_DEF  = 128;
    localparam int NUM_SLOTS_DEF = 6;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HOLDOFF   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HOLDOFF = 8'd1;
    localparam logic [HOLD_W-1:0]    PRESS_HOLDOFF_RST   = 8'd2;
    localparam logic [HOLD_W-1:0]    RELEASE_HOLDOFF_RST = 8'd3;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_ACK    = 1'b1;

    // Hold-off values used by the front
    typedef struct packed {
        logic [HOLD_W-1:0] press_holdoff;
        logic [HOLD_W-1:0] release_holdoff;
    } kde_cfg_t;

    // Request passed from the front to the back: an event or an acknowledge
    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic [SLOT_W-1:0] slot;
    } kde_req_t;

    // One result item
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic              changed;
    } kde_res_t;

endpackage

FILE: rtl/kde_front.sv
// Front part: accepts key samples and acknowledges, runs the per-key debounce.
// Uses kde_pkg; holds the per-key state memory with one valid bit per key.
module kde_front #(
    parameter int NUM_KEYS = kde_pkg::NUM_KEYS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kde_pkg::kde_cfg_t         cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_op,
    input  logic [kde_pkg::KEY_W-1:0]  in_key,
    input  logic                      in_level,
    input  logic [kde_pkg::SLOT_W-1:0] in_slot,
    output logic                      req_valid,
    input  logic                      req_ready,
    output kde_pkg::kde_req_t         req
);

    localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int ST_W   = kde_pkg::HOLD_W + 1;

    // Per-key state word: {key down, hold-off count}
    logic [ST_W-1:0]             key_mem [NUM_KEYS];
    logic [ST_W-1:0]             key_rdata_reg;
    logic [NUM_KEYS-1:0]         key_vld_reg;

    logic                        s1_vld_reg;
    logic                        s1_op_reg;
    logic [kde_pkg::KEY_W-1:0]   s1_key_reg;
    logic [KIDX_W-1:0]           s1_idx_reg;
    logic                        s1_inr_reg;
    logic                        s1_level_reg;
    logic [kde_pkg::SLOT_W-1:0]  s1_slot_reg;
    logic                        byp_reg;
    logic [ST_W-1:0]             byp_data_reg;

    logic [8:0]                  in_key9;
    logic [KIDX_W-1:0]           in_idx;
    logic                        in_inr;
    logic                        in_fire;
    logic [ST_W-1:0]             cur_st;
    logic [kde_pkg::HOLD_W-1:0]  cur_cnt;
    logic                        cur_down;
    logic                        is_event;
    logic                        s1_emit;
    logic                        s1_adv;
    logic                        mem_we;
    logic [ST_W-1:0]             mem_wdata;

    // Index and range check of the incoming key
    assign in_key9 = {2'b00, in_key};
    assign in_idx  = in_key9[KIDX_W-1:0];
    assign in_inr  = in_key9 < 9'(NUM_KEYS);

    // Current key state: forwarded write, stored word, or the reset value
    always_comb
    begin
        if (byp_reg)
        begin
            cur_st = byp_data_reg;
        end
        else if (key_vld_reg[s1_idx_reg])
        begin
            cur_st = key_rdata_reg;
        end
        else
        begin
            cur_st = '0;
        end
    end

    assign cur_cnt  = cur_st[kde_pkg::HOLD_W-1:0];
    assign cur_down = cur_st[ST_W-1];

    // Debounce decision for the sample in the stage
    assign is_event = s1_inr_reg && (cur_cnt == '0) && (s1_level_reg != cur_down);
    assign s1_emit  = (s1_op_reg == kde_pkg::OP_ACK) || is_event;
    assign s1_adv   = s1_vld_reg && (!s1_emit || req_ready);
    assign in_ready = !s1_vld_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    assign mem_we = s1_adv && (s1_op_reg == kde_pkg::OP_SAMPLE) && s1_inr_reg;

    // Next key state: count down, flip on a change, or keep
    always_comb
    begin
        if (cur_cnt != '0)
        begin
            mem_wdata = {cur_down, cur_cnt - 8'd1};
        end
        else if (is_event)
        begin
            mem_wdata = {s1_level_reg, s1_level_reg ? cfg.press_holdoff
                                                    : cfg.release_holdoff};
        end
        else
        begin
            mem_wdata = cur_st;
        end
    end

    // Request toward the queue
    assign req_valid   = s1_vld_reg && s1_emit;
    assign req.op      = s1_op_reg;
    assign req.key     = s1_key_reg;
    assign req.pressed = s1_level_reg;
    assign req.slot    = s1_slot_reg;

    // Per-key state memory, registered read at accept time
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_rdata_reg <= key_mem[in_idx];
        end
        if (mem_we)
        begin
            key_mem[s1_idx_reg] <= mem_wdata;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= in_op;
            s1_key_reg   <= in_key;
            s1_idx_reg   <= in_idx;
            s1_inr_reg   <= in_inr;
            s1_level_reg <= in_level;
            s1_slot_reg  <= in_slot;
            byp_data_reg <= mem_wdata;
        end
    end

    // Stage control, key valid bits and the write forwarding flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            byp_reg     <= 1'b0;
            key_vld_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_vld_reg <= 1'b1;
                byp_reg    <= mem_we && (in_idx == s1_idx_reg);
            end
            else if (s1_adv)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (mem_we)
            begin
                key_vld_reg[s1_idx_reg] <= 1'b1;
            end
        end
    end

endmodule

FILE: rtl/kde_queue.sv
// Short request queue between the front and the back.
// Uses kde_pkg for the request type and the depth.
module kde_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  kde_pkg::kde_req_t wr_req,
    output logic              rd_valid,
    input  logic              rd_ready,
    output kde_pkg::kde_req_t rd_req
);

    localparam int PTR_W = (kde_pkg::QUEUE_DEPTH > 1) ? $clog2(kde_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(kde_pkg::QUEUE_DEPTH + 1);

    kde_pkg::kde_req_t   entry_reg [kde_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                push;
    logic                pop;

    assign wr_ready = count_reg != CNT_W'(kde_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_req   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_req;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(kde_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(kde_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/kde_back.sv
// Back part: slot table, slot choice for events, acknowledges, output register.
// Uses kde_pkg for the request and result types.
module kde_back #(
    parameter int NUM_SLOTS = kde_pkg::NUM_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  kde_pkg::kde_req_t req,
    output logic              out_valid,
    input  logic              out_ready,
    output kde_pkg::kde_res_t out_res
);

    localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [kde_pkg::KEY_W-1:0]  slot_key_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]       slot_prs_reg;
    logic [NUM_SLOTS-1:0]       slot_pend_reg;
    logic                       out_vld_reg;
    kde_pkg::kde_res_t          out_res_reg;

    logic                       take;
    logic                       is_ack;
    logic                       slot_ok;
    logic [SIDX_W-1:0]          ack_idx;
    logic [kde_pkg::SLOT_W-1:0] match_slot;
    logic                       match_found;
    logic [kde_pkg::SLOT_W-1:0] free_slot;
    logic [kde_pkg::SLOT_W-1:0] ev_slot;
    logic [SIDX_W-1:0]          ev_idx;
    kde_pkg::kde_res_t          res_next;

    assign req_ready = !out_vld_reg || out_ready;
    assign take      = req_valid && req_ready;
    assign is_ack    = req.op == kde_pkg::OP_ACK;
    assign slot_ok   = {1'b0, req.slot} < (kde_pkg::SLOT_W + 1)'(NUM_SLOTS);
    assign ack_idx   = req.slot[SIDX_W-1:0];

    // Slot search: highest slot holding the key, else lowest slot not pending, else slot 0
    always_comb
    begin
        match_slot  = '0;
        match_found = 1'b0;
        free_slot   = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (slot_key_reg[s] == req.key)
            begin
                match_slot  = kde_pkg::SLOT_W'(s);
                match_found = 1'b1;
            end
        end
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (!slot_pend_reg[s])
            begin
                free_slot = kde_pkg::SLOT_W'(s);
            end
        end
    end

    assign ev_slot = match_found ? match_slot : free_slot;
    assign ev_idx  = ev_slot[SIDX_W-1:0];

    // Result of the request at the head of the queue
    always_comb
    begin
        if (!is_ack)
        begin
            res_next.slot    = ev_slot;
            res_next.key     = req.key;
            res_next.pressed = req.pressed;
            res_next.changed = 1'b1;
        end
        else if (slot_ok)
        begin
            res_next.slot    = req.slot;
            res_next.key     = slot_key_reg[ack_idx];
            res_next.pressed = slot_prs_reg[ack_idx];
            res_next.changed = slot_pend_reg[ack_idx];
        end
        else
        begin
            res_next.slot    = req.slot;
            res_next.key     = '0;
            res_next.pressed = 1'b0;
            res_next.changed = 1'b0;
        end
    end

    // Slot table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                slot_key_reg[s] <= '0;
            end
            slot_prs_reg  <= '0;
            slot_pend_reg <= '0;
        end
        else if (take)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if (!is_ack && (ev_idx == SIDX_W'(s)))
                begin
                    slot_key_reg[s]  <= req.key;
                    slot_prs_reg[s]  <= req.pressed;
                    slot_pend_reg[s] <= 1'b1;
                end
                else if (is_ack && slot_ok && (ack_idx == SIDX_W'(s)))
                begin
                    slot_pend_reg[s] <= 1'b0;
                end
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_res_reg <= res_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_res_reg;

endmodule

FILE: rtl/key_debounce_event_table_core.sv
// Top level of the key debounce event table: ports, configuration registers.
// Uses kde_pkg, kde_front, kde_queue and kde_back.
//
//  channel   direction  handshake                   contents
//  s_axis    in         s_axis_tvalid/tready        sample or acknowledge request
//  m_axis    out        m_axis_tvalid/tready        slot result
//  cfg       in         cfg_valid/cfg_ready         hold-off register write
//
// One request per cycle is accepted while nothing stalls; a result passes the front's stage
// register with the per-key state read, then an entry of the queue, then the back's output
// register, where the back's slot search ends.
// Reset clears per-key valid bits and the slot table at once; no clearing pass.
// A stalled output fills the output register and the queue before the input
// stalls; samples that cause no result pass without using the queue.
module key_debounce_event_table_core #(
    parameter int NUM_KEYS  = kde_pkg::NUM_KEYS_DEF,
    parameter int NUM_SLOTS = kde_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: key_number[6:0], level[7], slot_number[11:8], zero fill
    input  logic [kde_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: op[0]
    input  logic [0:0]                      s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: slot_out[3:0], key_out[10:4], pressed_out[11], changed_out[12], zero fill
    output logic [kde_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kde_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kde_pkg::HOLD_W-1:0]      cfg_data
);

    kde_pkg::kde_cfg_t  cfg_reg;
    kde_pkg::kde_req_t  fq_req;
    kde_pkg::kde_req_t  qb_req;
    kde_pkg::kde_res_t  out_res;
    logic               fq_valid;
    logic               fq_ready;
    logic               qb_valid;
    logic               qb_ready;

    assign cfg_ready = 1'b1;

    // Hold-off registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_holdoff   <= kde_pkg::PRESS_HOLDOFF_RST;
            cfg_reg.release_holdoff <= kde_pkg::RELEASE_HOLDOFF_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                kde_pkg::REG_PRESS_HOLDOFF:   cfg_reg.press_holdoff   <= cfg_data;
                kde_pkg::REG_RELEASE_HOLDOFF: cfg_reg.release_holdoff <= cfg_data;
                default: ;
            endcase
        end
    end

    // Debounce front
    kde_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser[0]),
        .in_key    (s_axis_tdata[6:0]),
        .in_level  (s_axis_tdata[7]),
        .in_slot   (s_axis_tdata[11:8]),
        .req_valid (fq_valid),
        .req_ready (fq_ready),
        .req       (fq_req)
    );

    // Request queue
    kde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_req   (fq_req),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_req   (qb_req)
    );

    // Slot table back
    kde_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (qb_valid),
        .req_ready (qb_ready),
        .req       (qb_req),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {3'b000, out_res.changed, out_res.pressed, out_res.key, out_res.slot};

endmodule

FILE: rtl/kde_checker.sv
// Port-level checks of the key debounce event table top level.
// Uses no package; attached to key_debounce_event_table_core by the bind below.
module kde_checker #(
    parameter int NUM_SLOTS = 6
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // No result is offered while reset is applied.
    a_no_out_in_reset: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result offered during reset");

    // An acknowledge of a slot beyond the table returns all-zero contents.
    a_bad_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ({1'b0, m_axis_tdata[3:0]} >= 5'(NUM_SLOTS)))
        |-> (m_axis_tdata[12:4] == 9'd0))
        else $error("nonzero contents for a slot beyond the table");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind key_debounce_event_table_core kde_checker #(
    .NUM_SLOTS (NUM_SLOTS)
) u_kde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

FILE: dv/key_debounce_event_table_core_tb.sv
// Self-checking testbench for key_debounce_event_table_core: per-key debounce and slot table.
// Needs kde_pkg and the core RTL; a built-in predictor supplies every expected slot result.
`timescale 1ns / 1ps

module key_debounce_event_table_core_tb;

    localparam int NKEYS  = kde_pkg::NUM_KEYS_DEF;
    localparam int NSLOTS = kde_pkg::NUM_SLOTS_DEF;

    // Register indexes that the block does not implement
    localparam logic [kde_pkg::CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd2;
    localparam logic [kde_pkg::CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    // Cycles to let pass after the last expected result before a register write
    localparam int SETTLE_CYCLES = 12;

    // One input request as the sender sees it
    typedef struct {
        logic                       op;
        logic [kde_pkg::KEY_W-1:0]  key;
        logic                       level;
        logic [kde_pkg::SLOT_W-1:0] slot;
    } key_req_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic [kde_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [0:0]                      s_axis_tuser = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [kde_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [kde_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [kde_pkg::HOLD_W-1:0]      cfg_data = '0;

    // Predicted state of the block
    logic [kde_pkg::HOLD_W-1:0] press_ho = kde_pkg::PRESS_HOLDOFF_RST;
    logic [kde_pkg::HOLD_W-1:0] release_ho = kde_pkg::RELEASE_HOLDOFF_RST;
    logic [kde_pkg::HOLD_W-1:0] holdoff_left [NKEYS];
    logic                       key_is_down [NKEYS];
    logic [kde_pkg::KEY_W-1:0]  tbl_key [NSLOTS];
    logic                       tbl_pressed [NSLOTS];
    logic                       tbl_pending [NSLOTS];

    key_req_t           pending_reqs [$];
    key_req_t           in_flight;
    kde_pkg::kde_res_t  slot_results_due [$];

    int n_sent = 0;
    int error_count = 0;
    int idle_mode = 0;
    int hold_left = 0;
    int holds_done = 0;
    int send_idle_pct;
    int recv_idle_pct;

    key_debounce_event_table_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a period of 8 ns.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Idle rates follow the progress of the run: sender light and receiver heavy,
    // then the other way round, then no idling at all.
    always_comb
    begin
        case (idle_mode)
            0:       begin send_idle_pct = 15; recv_idle_pct = 70; end
            1:       begin send_idle_pct = 70; recv_idle_pct = 15; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    end

    // Debounce one request against the predicted state and queue its slot result.
    task automatic debounce_step(input key_req_t r);
        kde_pkg::kde_res_t res;
        int  s;
        bit  found;
        begin
            found = 1'b0;
            s = 0;
            if (r.op == kde_pkg::OP_ACK) begin
                res.slot = r.slot;
                if (r.slot >= NSLOTS) begin
                    // Acknowledge of a slot that does not exist reads back zeros.
                    res.key = '0;
                    res.pressed = 1'b0;
                    res.changed = 1'b0;
                end else begin
                    res.key = tbl_key[r.slot];
                    res.pressed = tbl_pressed[r.slot];
                    res.changed = tbl_pending[r.slot];
                    tbl_pending[r.slot] = 1'b0;
                end
                slot_results_due.push_back(res);
            end else if (holdoff_left[r.key] != 0) begin
                holdoff_left[r.key] = holdoff_left[r.key] - 1'b1;
            end else if (r.level != key_is_down[r.key]) begin
                key_is_down[r.key] = r.level;
                holdoff_left[r.key] = r.level ? press_ho : release_ho;
                // Highest slot holding the key wins, then the lowest free one, else slot 0.
                for (int i = NSLOTS - 1; i >= 0; i--)
                    if (!found && tbl_key[i] == r.key) begin
                        s = i;
                        found = 1'b1;
                    end
                for (int i = 0; i < NSLOTS; i++)
                    if (!found && !tbl_pending[i]) begin
                        s = i;
                        found = 1'b1;
                    end
                tbl_key[s] = r.key;
                tbl_pressed[s] = r.level;
                tbl_pending[s] = 1'b1;
                res.slot = s[kde_pkg::SLOT_W-1:0];
                res.key = r.key;
                res.pressed = r.level;
                res.changed = 1'b1;
                slot_results_due.push_back(res);
            end
        end
    endtask

    // Request driver: offers queued requests and predicts each one as it is accepted.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                debounce_step(in_flight);
                n_sent <= n_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= in_flight.op;
                    s_axis_tdata <= {4'b0, in_flight.slot, in_flight.level, in_flight.key};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Idle mode and the long receiver hold-off, counted here in cycles.
    always @(posedge clk)
    begin
        if (rst_n) begin
            idle_mode <= (n_sent < 250) ? 0 : (n_sent < 500) ? 1 : 2;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if ((holds_done == 0 && n_sent >= 120) ||
                         (holds_done == 1 && n_sent >= 600)) begin
                hold_left <= 400;
                holds_done <= holds_done + 1;
            end
        end
    end

    // Result monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        kde_pkg::kde_res_t got;
        kde_pkg::kde_res_t want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.slot = m_axis_tdata[3:0];
                got.key = m_axis_tdata[10:4];
                got.pressed = m_axis_tdata[11];
                got.changed = m_axis_tdata[12];
                if (slot_results_due.size() == 0) begin
                    $display("%0t: unexpected result slot=%0d key=%0d pressed=%0b changed=%0b",
                             $time, got.slot, got.key, got.pressed, got.changed);
                    error_count++;
                end else begin
                    want = slot_results_due.pop_front();
                    if (got.slot !== want.slot || got.key !== want.key ||
                        got.pressed !== want.pressed || got.changed !== want.changed) begin
                        $display("%0t: mismatch expected slot=%0d key=%0d pressed=%0b changed=%0b",
                                 $time, want.slot, want.key, want.pressed, want.changed);
                        $display("%0t:          actual   slot=%0d key=%0d pressed=%0b changed=%0b",
                                 $time, got.slot, got.key, got.pressed, got.changed);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_req(input logic op, input int key, input logic level, input int slot);
        key_req_t r;
        begin
            r.op = op;
            r.key = key[kde_pkg::KEY_W-1:0];
            r.level = level;
            r.slot = slot[kde_pkg::SLOT_W-1:0];
            pending_reqs.push_back(r);
        end
    endtask

    // Mostly samples of a small pool of keys so that debounce and slot reuse are
    // exercised, with stray keys and acknowledges mixed in.
    task automatic add_random_requests(input int count);
        logic [kde_pkg::KEY_W-1:0] pool [8];
        key_req_t r;
        int pick;
        begin
            for (int i = 0; i < 8; i++)
                pool[i] = 7'($urandom_range(NKEYS - 1));
            for (int n = 0; n < count; n++) begin
                pick = $urandom_range(99);
                r.op = kde_pkg::OP_SAMPLE;
                r.key = pool[$urandom_range(7)];
                r.level = 1'($urandom_range(1));
                r.slot = 4'($urandom_range(15));
                if (pick < 30) begin
                    r.op = kde_pkg::OP_ACK;
                    r.key = 7'($urandom);
                    if (pick < 25)
                        r.slot = 4'($urandom_range(NSLOTS - 1));
                end else if (pick < 40) begin
                    r.key = 7'($urandom);
                end
                pending_reqs.push_back(r);
            end
        end
    endtask

    // Wait until every request is accepted and every result has come, then settle.
    task automatic wait_drained();
        begin
            do
                @(posedge clk);
            while (pending_reqs.size() != 0 || s_axis_tvalid || slot_results_due.size() != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [kde_pkg::CFG_IDX_W-1:0] index,
                             input logic [kde_pkg::HOLD_W-1:0] value);
        begin
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= index;
            cfg_data <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            if (index == kde_pkg::REG_PRESS_HOLDOFF)
                press_ho = value;
            else if (index == kde_pkg::REG_RELEASE_HOLDOFF)
                release_ho = value;
        end
    endtask

    // Main sequence: directed requests, then random phases under several hold-off settings.
    initial
    begin
        // Assert reset with a real falling edge so the block is cleared at once.
        rst_n <= 1'b0;
        for (int i = 0; i < NKEYS; i++) begin
            holdoff_left[i] = '0;
            key_is_down[i] = 1'b0;
        end
        for (int i = 0; i < NSLOTS; i++) begin
            tbl_key[i] = '0;
            tbl_pressed[i] = 1'b0;
            tbl_pending[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset contents, and acknowledges of slots that do not exist.
        push_req(kde_pkg::OP_ACK, 0, 1'b0, 0);
        push_req(kde_pkg::OP_ACK, 127, 1'b1, 15);
        push_req(kde_pkg::OP_ACK, 0, 1'b0, NSLOTS);
        push_req(kde_pkg::OP_ACK, 0, 1'b0, NSLOTS - 1);
        // Press of the top key, two ignored samples during hold-off, then release.
        push_req(kde_pkg::OP_SAMPLE, 127, 1'b1, 15);
        push_req(kde_pkg::OP_SAMPLE, 127, 1'b0, 0);
        push_req(kde_pkg::OP_SAMPLE, 127, 1'b0, 0);
        push_req(kde_pkg::OP_SAMPLE, 127, 1'b0, 0);
        // Key 0 matches the never-written slots, so the highest one is taken.
        push_req(kde_pkg::OP_SAMPLE, 0, 1'b1, 0);
        push_req(kde_pkg::OP_SAMPLE, 0, 1'b1, 0);
        // A sample equal to the key's state records nothing.
        push_req(kde_pkg::OP_SAMPLE, 5, 1'b0, 0);
        // Fill the table, then events with every slot pending fall on slot 0.
        for (int k = 1; k <= 4; k++)
            push_req(kde_pkg::OP_SAMPLE, k, 1'b1, 0);
        push_req(kde_pkg::OP_SAMPLE, 85, 1'b1, 10);
        push_req(kde_pkg::OP_SAMPLE, 42, 1'b1, 5);
        // Acknowledge twice: the mark reads back set, then clear.
        push_req(kde_pkg::OP_ACK, 0, 1'b0, 3);
        push_req(kde_pkg::OP_ACK, 0, 1'b0, 3);
        push_req(kde_pkg::OP_SAMPLE, 100, 1'b1, 0);
        push_req(kde_pkg::OP_ACK, 0, 1'b0, 3);
        push_req(kde_pkg::OP_ACK, 0, 1'b0, NSLOTS - 1);
        add_random_requests(140);
        wait_drained();

        // Writes to unimplemented indexes, then both hold-offs at zero.
        write_reg(REG_UNUSED_LOW, 8'hFF);
        write_reg(REG_UNUSED_HIGH, 8'h55);
        write_reg(kde_pkg::REG_PRESS_HOLDOFF, 8'd0);
        write_reg(kde_pkg::REG_RELEASE_HOLDOFF, 8'd0);
        add_random_requests(140);
        wait_drained();

        write_reg(kde_pkg::REG_PRESS_HOLDOFF, 8'd255);
        write_reg(kde_pkg::REG_RELEASE_HOLDOFF, 8'd1);
        add_random_requests(140);
        wait_drained();

        write_reg(kde_pkg::REG_PRESS_HOLDOFF, 8'd1);
        write_reg(kde_pkg::REG_RELEASE_HOLDOFF, 8'd255);
        add_random_requests(140);
        wait_drained();

        write_reg(kde_pkg::REG_PRESS_HOLDOFF, 8'($urandom_range(4)));
        write_reg(kde_pkg::REG_RELEASE_HOLDOFF, 8'($urandom_range(4)));
        add_random_requests(140);
        wait_drained();

        if (error_count == 0 && slot_results_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
